### hdl/calu_pkg.sv
`timescale 1ns / 1ps

package calu_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // issue queue depth (power of two)
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

endpackage

### hdl/calu_front.sv
`timescale 1ns / 1ps

// accepts operand beats, flags a zero divisor and stages them in a small queue
module calu_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  calu_pkg::cmd_t               in_cmd,
    input  logic signed [DATA_WIDTH-1:0] in_ar,
    input  logic signed [DATA_WIDTH-1:0] in_ai,
    input  logic signed [DATA_WIDTH-1:0] in_br,
    input  logic signed [DATA_WIDTH-1:0] in_bi,
    output logic                         q_valid,
    input  logic                         q_ready,
    output calu_pkg::cmd_t               q_cmd,
    output logic                         q_bzero,
    output logic signed [DATA_WIDTH-1:0] q_ar,
    output logic signed [DATA_WIDTH-1:0] q_ai,
    output logic signed [DATA_WIDTH-1:0] q_br,
    output logic signed [DATA_WIDTH-1:0] q_bi
);

    calu_pkg::cmd_t              cmd_mem  [calu_pkg::QDEPTH];
    logic                        bz_mem   [calu_pkg::QDEPTH];
    logic signed [DATA_WIDTH-1:0] ar_mem  [calu_pkg::QDEPTH];
    logic signed [DATA_WIDTH-1:0] ai_mem  [calu_pkg::QDEPTH];
    logic signed [DATA_WIDTH-1:0] br_mem  [calu_pkg::QDEPTH];
    logic signed [DATA_WIDTH-1:0] bi_mem  [calu_pkg::QDEPTH];

    logic [calu_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [calu_pkg::QAW:0]   cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != (calu_pkg::QAW+1)'(calu_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk) begin
        if (push) begin
            cmd_mem[wp_reg] <= in_cmd;
            bz_mem[wp_reg]  <= (in_br == '0) && (in_bi == '0);
            ar_mem[wp_reg]  <= in_ar;
            ai_mem[wp_reg]  <= in_ai;
            br_mem[wp_reg]  <= in_br;
            bi_mem[wp_reg]  <= in_bi;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign q_cmd   = cmd_mem[rp_reg];
    assign q_bzero = bz_mem[rp_reg];
    assign q_ar    = ar_mem[rp_reg];
    assign q_ai    = ai_mem[rp_reg];
    assign q_br    = br_mem[rp_reg];
    assign q_bi    = bi_mem[rp_reg];

endmodule

### hdl/calu_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
module calu_div #(
    parameter int NW = 64,
    parameter int DW = 64,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          out_v,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    logic [NW-1:0] n_reg [NW+1];
    logic [DW:0]   r_reg [NW+1];
    logic [DW-1:0] d_reg [NW+1];
    logic [TW-1:0] t_reg [NW+1];
    logic          v_reg [NW+1];

    always_comb begin
        n_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        t_reg[0] = tag_in;
        v_reg[0] = in_v;
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW+1:0] sh;
        logic [DW+1:0] df;
        logic [DW:0]   r_next;
        logic [NW-1:0] n_next;
        always_comb begin
            sh = {r_reg[s], n_reg[s][NW-1]};
            df = sh - {2'b00, d_reg[s]};
            if (!df[DW+1]) begin
                r_next = df[DW:0];
                n_next = {n_reg[s][NW-2:0], 1'b1};
            end
            else begin
                r_next = sh[DW:0];
                n_next = {n_reg[s][NW-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk) begin
            if (en) begin
                n_reg[s+1] <= n_next;
                r_reg[s+1] <= r_next;
                d_reg[s+1] <= d_reg[s];
                t_reg[s+1] <= t_reg[s];
            end
        end
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end
    end

    assign out_v   = v_reg[NW];
    assign quo     = n_reg[NW];
    assign tag_out = t_reg[NW];

endmodule

### hdl/calu_back.sv
`timescale 1ns / 1ps

// execution pipeline: products, sums, divide, saturation, output register
module calu_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  calu_pkg::cmd_t               q_cmd,
    input  logic                         q_bzero,
    input  logic signed [DATA_WIDTH-1:0] q_ar,
    input  logic signed [DATA_WIDTH-1:0] q_ai,
    input  logic signed [DATA_WIDTH-1:0] q_br,
    input  logic signed [DATA_WIDTH-1:0] q_bi,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output calu_pkg::status_t            status
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = PW + 1;            // sum of two products
    localparam int NW = SW + FRAC_BITS;    // shifted numerator magnitude
    localparam int TW = 4;                 // tag: divide flag, bzero, sign re, sign im

    // whole pipe advances when output register is free or being drained
    logic en;
    assign en      = !out_valid || out_ready;
    assign q_ready = en;

    // stage 1: products, add/sub results
    logic               v1_reg;
    calu_pkg::cmd_t     c1_reg;
    logic               z1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, d_rr_reg, d_ii_reg;
    logic signed [W:0]    as_r_reg, as_i_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            c1_reg   <= q_cmd;
            z1_reg   <= q_bzero;
            p_rr_reg <= PW'(q_ar) * PW'(q_br);
            p_ii_reg <= PW'(q_ai) * PW'(q_bi);
            p_ir_reg <= PW'(q_ai) * PW'(q_br);
            p_ri_reg <= PW'(q_ar) * PW'(q_bi);
            d_rr_reg <= PW'(q_br) * PW'(q_br);
            d_ii_reg <= PW'(q_bi) * PW'(q_bi);
            if (q_cmd == calu_pkg::CMD_SUB) begin
                as_r_reg <= (W+1)'(q_ar) - (W+1)'(q_br);
                as_i_reg <= (W+1)'(q_ai) - (W+1)'(q_bi);
            end
            else begin
                as_r_reg <= (W+1)'(q_ar) + (W+1)'(q_br);
                as_i_reg <= (W+1)'(q_ai) + (W+1)'(q_bi);
            end
        end
    end

    // stage 2: sums, division denominator
    logic               v2_reg;
    calu_pkg::cmd_t     c2_reg;
    logic               z2_reg;
    logic signed [SW-1:0] s_r_reg, s_i_reg;
    logic [PW:0]          den_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            c2_reg  <= c1_reg;
            z2_reg  <= z1_reg;
            den_reg <= {1'b0, d_rr_reg} + {1'b0, d_ii_reg};
            unique case (c1_reg)
                calu_pkg::CMD_MUL:
                begin
                    s_r_reg <= SW'(p_rr_reg) - SW'(p_ii_reg);
                    s_i_reg <= SW'(p_ir_reg) + SW'(p_ri_reg);
                end
                calu_pkg::CMD_DIV:
                begin
                    s_r_reg <= SW'(p_rr_reg) + SW'(p_ii_reg);
                    s_i_reg <= SW'(p_ir_reg) - SW'(p_ri_reg);
                end
                default:
                begin
                    s_r_reg <= SW'(as_r_reg);
                    s_i_reg <= SW'(as_i_reg);
                end
            endcase
        end
    end

    // stage 3: sign/magnitude for the divider; non-divide values ride in the same pipe
    logic [SW-1:0] mag_r, mag_i;
    logic [NW-1:0] num_r, num_i;
    logic [PW:0]   den_in;
    logic [TW-1:0] tag3;
    logic          div_path;

    assign div_path = (c2_reg == calu_pkg::CMD_DIV) && !z2_reg;
    assign mag_r    = s_r_reg[SW-1] ? SW'(-s_r_reg) : SW'(s_r_reg);
    assign mag_i    = s_i_reg[SW-1] ? SW'(-s_i_reg) : SW'(s_i_reg);
    // for non-divide items and zero divisors the divider sees den = 1, so quotient = value
    assign num_r    = div_path ? (NW'(mag_r) << FRAC_BITS) :
                      (c2_reg == calu_pkg::CMD_MUL ? NW'(mag_r >> FRAC_BITS) : NW'(mag_r));
    assign num_i    = div_path ? (NW'(mag_i) << FRAC_BITS) :
                      (c2_reg == calu_pkg::CMD_MUL ? NW'(mag_i >> FRAC_BITS) : NW'(mag_i));
    assign den_in   = div_path ? den_reg : (PW+1)'(1);
    assign tag3     = {c2_reg == calu_pkg::CMD_DIV, z2_reg, s_r_reg[SW-1], s_i_reg[SW-1]};

    logic          vq_r, vq_i;
    logic [NW-1:0] qr, qi;
    logic [TW-1:0] tq_r, tq_i;

    calu_div #(.NW(NW), .DW(PW+1), .TW(TW)) u_div_r (
        .clk(clk), .rst_n(rst_n), .en(en), .in_v(v2_reg),
        .num(num_r), .den(den_in), .tag_in(tag3),
        .out_v(vq_r), .quo(qr), .tag_out(tq_r)
    );
    calu_div #(.NW(NW), .DW(PW+1), .TW(TW)) u_div_i (
        .clk(clk), .rst_n(rst_n), .en(en), .in_v(v2_reg),
        .num(num_i), .den(den_in), .tag_in(tag3),
        .out_v(vq_i), .quo(qi), .tag_out(tq_i)
    );

    // saturation
    logic          ov_r, ov_i;
    logic [W-1:0]  sat_r, sat_i;
    logic [NW-1:0] lim;

    assign lim = NW'(1) << (W - 1);

    always_comb begin
        ov_r = 1'b0;
        ov_i = 1'b0;
        if (tq_r[1]) begin
            if (qr > lim) begin
                ov_r  = 1'b1;
                sat_r = lim[W-1:0];
            end
            else
                sat_r = W'(-qr);
        end
        else begin
            if (qr > lim - NW'(1)) begin
                ov_r  = 1'b1;
                sat_r = W'(lim - NW'(1));
            end
            else
                sat_r = qr[W-1:0];
        end
        if (tq_r[0]) begin
            if (qi > lim) begin
                ov_i  = 1'b1;
                sat_i = lim[W-1:0];
            end
            else
                sat_i = W'(-qi);
        end
        else begin
            if (qi > lim - NW'(1)) begin
                ov_i  = 1'b1;
                sat_i = W'(lim - NW'(1));
            end
            else
                sat_i = qi[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en) begin
            v1_reg    <= q_valid;
            v2_reg    <= v1_reg;
            out_valid <= vq_r;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            if (tq_r[3] && tq_r[2]) begin
                res_real <= '0;
                res_imag <= '0;
                status   <= calu_pkg::ST_DIV_ZERO;
            end
            else begin
                res_real <= sat_r;
                res_imag <= sat_i;
                status   <= (ov_r || ov_i) ? calu_pkg::ST_OVERFLOW : calu_pkg::ST_OK;
            end
        end
    end

    logic unused_v;
    assign unused_v = vq_i ^ (|tq_i);

endmodule

### hdl/complex_alu.sv
`timescale 1ns / 1ps

// path from accept to result valid: queue, 2 product/sum stages, divider, output
// throughput: one beat per cycle while the back end is not stalled; all operations
// share the bit-per-stage divider pipeline
// the back end stalls as a whole when the output register is held
// reset: asynchronous active-low rst_n clears queue pointers and valid flags only
module complex_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output logic [1:0]                   status
);

    // front to back queue beat
    logic                         q_valid, q_ready, q_bzero;
    calu_pkg::cmd_t               q_cmd;
    logic signed [DATA_WIDTH-1:0] q_ar, q_ai, q_br, q_bi;
    calu_pkg::status_t            st;

    calu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_cmd(calu_pkg::cmd_t'(cmd)),
        .in_ar(a_real), .in_ai(a_imag), .in_br(b_real), .in_bi(b_imag),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_bzero(q_bzero),
        .q_ar(q_ar), .q_ai(q_ai), .q_br(q_br), .q_bi(q_bi)
    );

    calu_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_bzero(q_bzero),
        .q_ar(q_ar), .q_ai(q_ai), .q_br(q_br), .q_bi(q_bi),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_real(res_real), .res_imag(res_imag), .status(st)
    );

    assign status = st;

endmodule

### hdl/calu_checker.sv
`timescale 1ns / 1ps

module calu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [31:0] res_real,
    input logic [31:0] res_imag
);

    // held result beat stays valid with its status unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result beat dropped or changed");

    // status never takes the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");

    // divide by zero returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 2'd1 |-> res_real == '0 && res_imag == '0)
        else $error("nonzero result on divide by zero");

endmodule

bind complex_alu calu_checker u_calu_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .res_real(res_real[31:0]), .res_imag(res_imag[31:0])
);

### dv/tb_complex_alu.sv
`timescale 1ns / 1ps

module tb_complex_alu;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        calu_pkg::status_t    st;
    } cplx_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           cmd;
    logic signed [DW-1:0] a_real;
    logic signed [DW-1:0] a_imag;
    logic signed [DW-1:0] b_real;
    logic signed [DW-1:0] b_imag;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [DW-1:0] res_real;
    logic signed [DW-1:0] res_imag;
    logic [1:0]           status;

    cplx_result_t expected_results[$];
    int           fail_count;
    int           idle_cycles;
    bit           no_idle;     // quiet stretch: neither side idles

    complex_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // clamp an exact signed value to the data width, flag when clamped
    function automatic logic signed [DW-1:0] clamp_part(input logic signed [159:0] v,
                                                         inout bit ovf);
        logic signed [159:0] hi;
        logic signed [159:0] lo;
        hi = (160'sd1 <<< (DW - 1)) - 1;
        lo = -(160'sd1 <<< (DW - 1));
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // truncating (toward zero) signed shift right
    function automatic logic signed [159:0] shr_trunc(input logic signed [159:0] v);
        logic signed [159:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    // exact complex arithmetic, then saturation
    function automatic cplx_result_t complex_result(input calu_pkg::cmd_t op,
        input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
        input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
        logic signed [159:0] xr, xi, yr, yi, re, im, den;
        cplx_result_t r;
        bit ovf;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        ovf = 1'b0;
        case (op)
            calu_pkg::CMD_ADD:
            begin
                re = xr + yr;
                im = xi + yi;
            end
            calu_pkg::CMD_SUB:
            begin
                re = xr - yr;
                im = xi - yi;
            end
            calu_pkg::CMD_MUL:
            begin
                re = shr_trunc(xr * yr - xi * yi);
                im = shr_trunc(xi * yr + xr * yi);
            end
            default:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                begin
                    r.re = '0;
                    r.im = '0;
                    r.st = calu_pkg::ST_DIV_ZERO;
                    return r;
                end
                // signed division truncates toward zero
                re = ((xr * yr + xi * yi) <<< FB) / den;
                im = ((xi * yr - xr * yi) <<< FB) / den;
            end
        endcase
        r.re = clamp_part(re, ovf);
        r.im = clamp_part(im, ovf);
        r.st = ovf ? calu_pkg::ST_OVERFLOW : calu_pkg::ST_OK;
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 26);
    endfunction

    // send one beat; valid stays up across back-to-back beats
    task automatic send_beat(input calu_pkg::cmd_t op, input logic [DW-1:0] ar,
                             input logic [DW-1:0] ai, input logic [DW-1:0] br,
                             input logic [DW-1:0] bi);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        a_real   <= ar;
        a_imag   <= ai;
        b_real   <= br;
        b_imag   <= bi;
        expected_results.push_back(complex_result(op, ar, ai, br, bi));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [DW-1:0] rand_part();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(2) == 0 ? 32'h0 : 32'h0001_0000;
            3: return {{16{$urandom_range(1) == 1'b1}}, 16'($urandom)};   // small
            4: return 32'($signed(20'($urandom)));                        // mid
            default: return $urandom;
        endcase
    endfunction

    // operand extremes, five rotations per operation
    task automatic test_extremes();
        logic [DW-1:0] edges[5];
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000};
        for (int op = 0; op < 4; op++)
            for (int k = 0; k < 5; k++)
                send_beat(calu_pkg::cmd_t'(op), edges[k], edges[(k + 1) % 5],
                          edges[(k + 2) % 5], edges[(k + 3) % 5]);
    endtask

    // zero divisor and saturation in both directions
    task automatic test_special();
        send_beat(calu_pkg::CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_beat(calu_pkg::CMD_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
        send_beat(calu_pkg::CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff);
        send_beat(calu_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff);
        send_beat(calu_pkg::CMD_DIV, 32'h7fff_ffff, 32'h0, 32'h1, 32'h0);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            no_idle = (n >= 200 && n < 300);
            send_beat(calu_pkg::cmd_t'($urandom_range(3)), rand_part(), rand_part(),
                      rand_part(), rand_part());
        end
        no_idle = 1'b0;
    endtask

    // result side: random back-pressure and field compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                cplx_result_t exp_r;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (res_real !== exp_r.re)
                    begin
                        $error("res_real expected %h actual %h", exp_r.re, res_real);
                        fail_count++;
                    end
                    if (res_imag !== exp_r.im)
                    begin
                        $error("res_imag expected %h actual %h", exp_r.im, res_imag);
                        fail_count++;
                    end
                    if (status !== exp_r.st)
                    begin
                        $error("status expected %0d actual %0d", exp_r.st, status);
                        fail_count++;
                    end
                end
            end
            out_ready <= !idle_now();
        end
    end

    // watchdog on cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("complex_alu regression: fail");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        cmd       = calu_pkg::CMD_ADD;
        a_real    = '0;
        a_imag    = '0;
        b_real    = '0;
        b_imag    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_special();
        test_random(650);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * DW + FB + 20) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("complex_alu regression: pass");
        else
            $display("complex_alu regression: fail");
        $finish;
    end

endmodule

### files.f
hdl/calu_pkg.sv
hdl/calu_front.sv
hdl/calu_div.sv
hdl/calu_back.sv
hdl/complex_alu.sv
hdl/calu_checker.sv
dv/tb_complex_alu.sv
